// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the up/down counter reporter.
// Each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER_CLK(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/udc_pkg.sv =====
// Types and constants for the up/down counter with ASCII serial reporter.
// No dependencies.
package udc_pkg;

  typedef enum logic [1:0] {
    ActPortChange = 2'd0,
    ActPoll       = 2'd1,
    ActTxReady    = 2'd2
  } action_e;

  localparam logic [7:0] PortUpPattern   = 8'hFE;
  localparam logic [7:0] PortDownPattern = 8'hFD;
  localparam logic [7:0] AsciiZero       = 8'h30;
  localparam logic [7:0] AsciiComma      = 8'd44;

  localparam logic [4:0] SlotHundreds = 5'd1;
  localparam logic [4:0] SlotTens     = 5'd2;
  localparam logic [4:0] SlotUnits    = 5'd3;
  localparam logic [4:0] SlotComma    = 5'd4;
  localparam logic [4:0] SlotWrap     = 5'd20;

endpackage

// ===== sv/updown_counter_ascii_reporter.sv =====
// Up/down counter with ASCII serial reporter, top level. Uses udc_pkg and assert_macros.svh.
// Result valid follows input accept in the next cycle; the result register is the only stage.
// Throughput: one item per cycle; a new item is taken whenever the result register is empty
// or its result is taken in the same cycle.
// Reset: asynchronous, active low; clears the armed bits, counter, slot and result valid.
module updown_counter_ascii_reporter
  import udc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] port_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] count_value_o
);

  logic       up_armed_q, up_armed_d;
  logic       down_armed_q, down_armed_d;
  logic [7:0] count_q, count_d;
  logic [4:0] slot_q, slot_d;
  logic       out_valid_q, out_valid_d;
  logic       tx_valid_q, tx_valid_d;
  logic [7:0] tx_byte_q, tx_byte_d;
  logic [7:0] count_value_q;

  logic        in_accept;
  logic [4:0]  slot_next;
  logic [1:0]  hundreds;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  units_full;
  logic [3:0]  units;
  logic        tx_byte_legal;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    if (count_q >= 8'd200) begin
      hundreds = 2'd2;
      rem      = 7'(count_q - 8'd200);
    end else if (count_q >= 8'd100) begin
      hundreds = 2'd1;
      rem      = 7'(count_q - 8'd100);
    end else begin
      hundreds = 2'd0;
      rem      = count_q[6:0];
    end
    tens_prod  = {8'b0, rem} * 15'd205;
    tens       = tens_prod[14:11];
    units_full = rem - 7'({3'b0, tens} * 7'd10);
    units      = units_full[3:0];
  end

  assign slot_next = slot_q + 5'd1;

  always_comb begin
    up_armed_d   = up_armed_q;
    down_armed_d = down_armed_q;
    count_d      = count_q;
    slot_d       = slot_q;
    tx_valid_d   = 1'b0;
    tx_byte_d    = 8'd0;
    if (in_accept) begin
      case (action_i)
        ActPortChange: begin
          if (port_value_i == PortUpPattern) begin
            up_armed_d = 1'b1;
          end else if (port_value_i == PortDownPattern) begin
            down_armed_d = 1'b1;
          end else begin
            up_armed_d   = 1'b0;
            down_armed_d = 1'b0;
          end
        end
        ActPoll: begin
          if (up_armed_q && !port_value_i[0] && !(down_armed_q && !port_value_i[1])) begin
            count_d = count_q + 8'd1;
          end else if (down_armed_q && !port_value_i[1]
                       && !(up_armed_q && !port_value_i[0])) begin
            count_d = count_q - 8'd1;
          end
          if (up_armed_q && !port_value_i[0]) begin
            up_armed_d = 1'b0;
          end
          if (down_armed_q && !port_value_i[1]) begin
            down_armed_d = 1'b0;
          end
        end
        ActTxReady: begin
          slot_d = slot_next;
          case (slot_next)
            SlotHundreds: begin
              tx_valid_d = 1'b1;
              tx_byte_d  = AsciiZero + {6'b0, hundreds};
            end
            SlotTens: begin
              tx_valid_d = 1'b1;
              tx_byte_d  = AsciiZero + {4'b0, tens};
            end
            SlotUnits: begin
              tx_valid_d = 1'b1;
              tx_byte_d  = AsciiZero + {4'b0, units};
            end
            SlotComma: begin
              tx_valid_d = 1'b1;
              tx_byte_d  = AsciiComma;
            end
            SlotWrap: begin
              slot_d = 5'd0;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_armed_q   <= 1'b0;
      down_armed_q <= 1'b0;
      count_q      <= 8'd0;
      slot_q       <= 5'd0;
      out_valid_q  <= 1'b0;
    end else begin
      up_armed_q   <= up_armed_d;
      down_armed_q <= down_armed_d;
      count_q      <= count_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tx_valid_q    <= tx_valid_d;
      tx_byte_q     <= tx_byte_d;
      count_value_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = tx_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign count_value_o = count_value_q;

  assign tx_byte_legal = (tx_byte_q == AsciiComma)
                         || (tx_byte_q >= AsciiZero && tx_byte_q <= AsciiZero + 8'd9);

`include "assert_macros.svh"

  `ASSERT_NEVER_CLK(a_slot_range, slot_q > SlotWrap, "send slot beyond wrap point")
  `ASSERT_CLK(a_accept_fills, in_accept |=> out_valid_q, "accepted item left no result")
  `ASSERT_CLK(a_tx_byte_ascii, (out_valid_q && tx_valid_q) |-> tx_byte_legal, "bad tx byte")

endmodule

// ===== test/tb_updown_counter_ascii_reporter.sv =====
// Self-checking testbench for updown_counter_ascii_reporter: button presses, serial digit slots.
// A queued driver and a clocked monitor check every result against a built-in counter model.
// Depends on udc_pkg and the RTL of the block only.
module tb_updown_counter_ascii_reporter;
  import udc_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int NumItems = 1250;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] port;
  } button_evt_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] count;
  } report_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] action_i = ActPortChange;
  logic [7:0] port_value_i = 8'hFF;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic [7:0] count_value_o;

  button_evt_t event_q[$];
  report_t     report_q[$];

  logic       arm_up = 1'b0;
  logic       arm_down = 1'b0;
  logic [7:0] cnt = 8'd0;
  logic [4:0] slot = 5'd0;

  logic in_taken = 1'b0;
  logic long_hold = 1'b0;
  int   n_total;
  int   n_in = 0;
  int   n_out = 0;
  int   n_err = 0;
  int   n_bytes = 0;
  int   n_steps = 0;
  int   n_wraps = 0;
  int   max_cnt = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   rx_mode = 0;
  int   rx_left = 0;

  updown_counter_ascii_reporter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .port_value_i (port_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .count_value_o(count_value_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic note_mismatch(input string msg);
    n_err++;
    $display("MISMATCH result %0d: %s", n_out, msg);
  endtask

  task automatic advance_counter(input logic [1:0] act, input logic [7:0] port);
    report_t r;
    r = '{tx_valid: 1'b0, tx_byte: 8'd0, count: 8'd0};
    case (act)
      ActPortChange: begin
        if (port == PortUpPattern) begin
          arm_up = 1'b1;
        end else if (port == PortDownPattern) begin
          arm_down = 1'b1;
        end else begin
          arm_up = 1'b0;
          arm_down = 1'b0;
        end
      end
      ActPoll: begin
        if (arm_up && !port[0]) begin
          cnt = cnt + 8'd1;
          arm_up = 1'b0;
          n_steps++;
        end
        if (arm_down && !port[1]) begin
          cnt = cnt - 8'd1;
          arm_down = 1'b0;
          n_steps++;
        end
      end
      ActTxReady: begin
        slot = slot + 5'd1;
        case (slot)
          SlotHundreds: r.tx_byte = AsciiZero + cnt / 8'd100;
          SlotTens:     r.tx_byte = AsciiZero + (cnt / 8'd10) % 8'd10;
          SlotUnits:    r.tx_byte = AsciiZero + cnt % 8'd10;
          SlotComma:    r.tx_byte = AsciiComma;
          SlotWrap: begin
            slot = 5'd0;
            n_wraps++;
          end
          default: ;
        endcase
        r.tx_valid = (r.tx_byte != 8'd0);
        if (r.tx_valid) n_bytes++;
      end
      default: ;
    endcase
    r.count = cnt;
    if (int'(cnt) > max_cnt) max_cnt = int'(cnt);
    report_q.push_back(r);
  endtask

  task automatic queue_evt(input logic [1:0] act, input logic [7:0] port);
    event_q.push_back('{action: act, port: port});
  endtask

  // arm one button, then poll with its bit low and the rest random
  task automatic queue_press(input bit down);
    logic [7:0] p;
    p = 8'($urandom);
    if (down) begin
      queue_evt(ActPortChange, PortDownPattern);
      p[1] = 1'b0;
    end else begin
      queue_evt(ActPortChange, PortUpPattern);
      p[0] = 1'b0;
    end
    queue_evt(ActPoll, p);
  endtask

  always @(negedge clk_i) begin : sender
    button_evt_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (event_q.size() > 0) begin
        nxt = event_q.pop_front();
        in_valid_i   <= 1'b1;
        action_i     <= nxt.action;
        port_value_i <= nxt.port;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 64);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       rdy = 1'b1;
      1:       rdy = 1'($urandom_range(0, 1));
      2:       rdy = ($urandom_range(0, 4) != 0);
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    out_ready_i <= rdy && !long_hold && rst_ni;
  end

  always @(posedge clk_i) begin : monitor
    report_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (report_q.size() == 0) begin
          note_mismatch("result with nothing pending");
        end else begin
          want = report_q.pop_front();
          if (tx_valid_o !== want.tx_valid)
            note_mismatch($sformatf("tx_valid got %b want %b", tx_valid_o, want.tx_valid));
          if (tx_byte_o !== want.tx_byte)
            note_mismatch($sformatf("tx_byte got %0d want %0d", tx_byte_o, want.tx_byte));
          if (count_value_o !== want.count)
            note_mismatch($sformatf("count_value got %0d want %0d", count_value_o, want.count));
        end
        n_out++;
      end
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        advance_counter(action_i, port_value_i);
        n_in++;
      end
    end
  end

  // hold the receiver off long enough for the block to back up its input
  initial begin
    while (n_in < 500) @(negedge clk_i);
    long_hold <= 1'b1;
    repeat (80) @(negedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    #2_400_000;
    $display("TIMEOUT: %0d of %0d items accepted, %0d results pending", n_in, n_total,
             report_q.size());
    $display("updown_counter_ascii_reporter regression: fail");
    $finish;
  end

  initial begin
    int kind;
    int len;
    bit dir;
    logic [1:0] act;

    queue_evt(ActPortChange, PortDownPattern);
    queue_evt(ActPoll, 8'hFF);
    queue_evt(ActPoll, 8'hFD);
    repeat (4) queue_evt(ActTxReady, 8'h00);
    queue_evt(ActPortChange, PortUpPattern);
    queue_evt(ActPoll, 8'h00);
    queue_evt(ActPortChange, PortUpPattern);
    queue_evt(ActPortChange, PortDownPattern);
    queue_evt(ActPoll, 8'hFC);
    queue_evt(ActPortChange, PortUpPattern);
    queue_evt(ActPortChange, 8'hFF);
    queue_evt(ActPoll, 8'h00);
    queue_evt(ActPortChange, PortDownPattern);
    queue_evt(ActPortChange, 8'h00);
    queue_evt(ActPoll, 8'h00);
    queue_evt(ActUnused, 8'hFF);
    queue_evt(ActUnused, 8'h00);
    queue_evt(ActPortChange, PortUpPattern);
    queue_evt(ActPoll, 8'hFE);
    queue_evt(ActTxReady, 8'hFF);

    while (event_q.size() < NumItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        queue_press(1'($urandom_range(0, 1)));
      end else if (kind < 40) begin
        dir = 1'($urandom_range(0, 1));
        len = $urandom_range(5, 40);
        repeat (len) queue_press(dir);
      end else if (kind < 75) begin
        len = $urandom_range(1, 24);
        repeat (len) queue_evt(ActTxReady, 8'($urandom));
      end else if (kind < 90) begin
        queue_evt(ActPortChange, PortUpPattern);
        queue_evt(ActPortChange, PortDownPattern);
        queue_evt(ActPoll, 8'($urandom));
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          act = 2'($urandom_range(0, 3));
          queue_evt(act, 8'($urandom));
        end
      end
    end
    n_total = event_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_in < n_total) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("run covered %0d items and %0d results: %0d bytes sent, %0d counter steps,",
             n_in, n_out, n_bytes, n_steps);
    $display("%0d slot wraps, counter peak %0d, %0d mismatches", n_wraps, max_cnt, n_err);
    if (n_err == 0) begin
      $display("updown_counter_ascii_reporter regression: pass");
    end else begin
      $display("updown_counter_ascii_reporter regression: fail");
    end
    $finish;
  end

endmodule
